// File: src/cvm_pkg.sv
package cvm_pkg;

    // Magnitude bound used when scaling a vector before its squared length.
    localparam int NORM_BITS = 31;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BAD_W    = 2'd1,
        ST_ZERO_LEN = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        N_IDLE,
        N_SHIFT,
        N_SQUARE,
        N_SQRT,
        N_PREP,
        N_DIV,
        N_DONE
    } norm_state_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_NORM_W,
        B_NORM_U,
        B_CROSS,
        B_OFFS,
        B_EMIT
    } back_state_t;

endpackage

// File: src/cvm_setup_if.sv
interface cvm_setup_if #(parameter int DATA_WIDTH = 32);
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] pos_x;
    logic signed [DATA_WIDTH-1:0] pos_y;
    logic signed [DATA_WIDTH-1:0] pos_z;
    logic signed [DATA_WIDTH-1:0] pos_w;
    logic signed [DATA_WIDTH-1:0] view_x;
    logic signed [DATA_WIDTH-1:0] view_y;
    logic signed [DATA_WIDTH-1:0] view_z;
    logic signed [DATA_WIDTH-1:0] view_w;
    logic signed [DATA_WIDTH-1:0] up_x;
    logic signed [DATA_WIDTH-1:0] up_y;
    logic signed [DATA_WIDTH-1:0] up_z;

    modport source (
        output valid, pos_x, pos_y, pos_z, pos_w, view_x, view_y, view_z, view_w,
        output up_x, up_y, up_z,
        input  ready
    );
    modport sink (
        input  valid, pos_x, pos_y, pos_z, pos_w, view_x, view_y, view_z, view_w,
        input  up_x, up_y, up_z,
        output ready
    );
endinterface

// File: src/cvm_row_if.sv
interface cvm_row_if #(parameter int DATA_WIDTH = 32);
    logic                         valid;
    logic                         ready;
    logic [1:0]                   row_index;
    logic signed [DATA_WIDTH-1:0] elem_x;
    logic signed [DATA_WIDTH-1:0] elem_y;
    logic signed [DATA_WIDTH-1:0] elem_z;
    logic signed [DATA_WIDTH-1:0] offset;
    logic [1:0]                   status;
    logic                         last_row;

    modport source (
        output valid, row_index, elem_x, elem_y, elem_z, offset, status, last_row,
        input  ready
    );
    modport sink (
        input  valid, row_index, elem_x, elem_y, elem_z, offset, status, last_row,
        output ready
    );
endinterface

// File: src/cvm_front.sv
module cvm_front
    import cvm_pkg::*;
#(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS = 16,
    localparam int WW = DATA_WIDTH + 1,
    localparam int CW = 2 * DATA_WIDTH + 2,
    localparam int EW = 2 + 3 * DATA_WIDTH + 3 * WW + 3 * CW
) (
    input  logic          clk,
    input  logic          rst_n,
    cvm_setup_if.sink     setup,
    input  logic          room,
    output logic          push,
    output logic [EW-1:0] entry
);

    localparam int PW = DATA_WIDTH + WW;
    localparam logic signed [DATA_WIDTH-1:0] ONE = DATA_WIDTH'(1) << FRAC_BITS;

    logic signed [WW-1:0] wr_x, wr_y, wr_z;
    logic signed [PW-1:0] m_next [6];
    logic                 en, acc;

    logic                         valid_reg;
    logic signed [DATA_WIDTH-1:0] p_reg [3];
    logic signed [WW-1:0]         w_reg [3];
    logic signed [PW-1:0]         m_reg [6];
    logic                         bad_reg, wzero_reg;

    logic signed [CW-1:0] ur_x, ur_y, ur_z;
    status_t              status;

    // w = -view, one extra bit so the most negative input negates exactly
    assign wr_x = -WW'(setup.view_x);
    assign wr_y = -WW'(setup.view_y);
    assign wr_z = -WW'(setup.view_z);

    // up x w partial products
    assign m_next[0] = setup.up_y * wr_z;
    assign m_next[1] = setup.up_z * wr_y;
    assign m_next[2] = setup.up_z * wr_x;
    assign m_next[3] = setup.up_x * wr_z;
    assign m_next[4] = setup.up_x * wr_y;
    assign m_next[5] = setup.up_y * wr_x;

    assign en          = !valid_reg || room;
    assign setup.ready = en;
    assign acc         = setup.valid && en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= setup.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            p_reg[0]  <= setup.pos_x;
            p_reg[1]  <= setup.pos_y;
            p_reg[2]  <= setup.pos_z;
            w_reg[0]  <= wr_x;
            w_reg[1]  <= wr_y;
            w_reg[2]  <= wr_z;
            m_reg     <= m_next;
            bad_reg   <= (setup.pos_w != ONE) || (setup.view_w != '0);
            wzero_reg <= (setup.view_x == '0) && (setup.view_y == '0)
                         && (setup.view_z == '0);
        end
    end

    assign ur_x = CW'(m_reg[0]) - CW'(m_reg[1]);
    assign ur_y = CW'(m_reg[2]) - CW'(m_reg[3]);
    assign ur_z = CW'(m_reg[4]) - CW'(m_reg[5]);

    always_comb
    begin
        if (bad_reg)
            status = ST_BAD_W;
        else if (wzero_reg || (ur_x == '0 && ur_y == '0 && ur_z == '0))
            status = ST_ZERO_LEN;
        else
            status = ST_OK;
    end

    assign push  = valid_reg && room;
    assign entry = {status, p_reg[0], p_reg[1], p_reg[2],
                    w_reg[0], w_reg[1], w_reg[2], ur_x, ur_y, ur_z};

endmodule

// File: src/cvm_fifo.sv
module cvm_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             room,
    input  logic             pop,
    output logic             avail,
    output logic [WIDTH-1:0] rdata
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] mem [DEPTH];
    logic [AW-1:0]    wr_reg, rd_reg;
    logic [AW:0]      count_reg;

    assign room  = count_reg != (AW + 1)'(DEPTH);
    assign avail = count_reg != '0;
    assign rdata = mem[rd_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
                wr_reg <= (wr_reg == AW'(DEPTH - 1)) ? '0 : wr_reg + 1'b1;
            if (pop)
                rd_reg <= (rd_reg == AW'(DEPTH - 1)) ? '0 : rd_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_reg] <= wdata;
    end

endmodule

// File: src/cvm_norm.sv
module cvm_norm
    import cvm_pkg::*;
#(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS = 16,
    localparam int CW = 2 * DATA_WIDTH + 2,
    localparam int UW = FRAC_BITS + 2
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic signed [CW-1:0] c_x,
    input  logic signed [CW-1:0] c_y,
    input  logic signed [CW-1:0] c_z,
    output logic                 done,
    output logic signed [UW-1:0] q_x,
    output logic signed [UW-1:0] q_y,
    output logic signed [UW-1:0] q_z
);

    localparam int NB   = NORM_BITS;
    localparam int SQW  = 2 * NB + 2;
    localparam int RW   = SQW / 2;
    localparam int QW   = FRAC_BITS + 1;
    localparam int NW   = NB + FRAC_BITS + 1;
    localparam int CMAX = (RW > QW) ? RW : QW;
    localparam int CNTW = $clog2(CMAX);
    localparam logic [SQW-1:0] BIT_INIT = SQW'(1) << (SQW - 2);

    norm_state_t state_reg, state_next;

    logic [CW-1:0]   a_reg [3];
    logic            neg_reg [3];
    logic [SQW-1:0]  n_reg, res_reg, bit_reg;
    logic [1:0]      k_reg;
    logic [CNTW-1:0] cnt_reg;
    logic [RW-1:0]   rem_reg [3];
    logic [QW-1:0]   lo_reg [3];
    logic [QW-1:0]   q_reg [3];

    logic            any_hi;
    logic [NB-1:0]   a_sel;
    logic [2*NB-1:0] sq;
    logic [SQW-1:0]  trial;
    logic [RW-1:0]   root;

    function automatic logic [CW-1:0] mag(input logic signed [CW-1:0] v);
        return v[CW-1] ? CW'(-v) : CW'(v);
    endfunction

    assign any_hi = (|a_reg[0][CW-1:NB]) || (|a_reg[1][CW-1:NB]) || (|a_reg[2][CW-1:NB]);

    always_comb
    begin
        case (k_reg)
            2'd0:    a_sel = a_reg[0][NB-1:0];
            2'd1:    a_sel = a_reg[1][NB-1:0];
            default: a_sel = a_reg[2][NB-1:0];
        endcase
    end

    assign sq    = a_sel * a_sel;
    assign trial = res_reg + bit_reg;
    assign root  = res_reg[RW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= N_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        done       = 1'b0;
        case (state_reg)
            N_IDLE:   if (start) state_next = N_SHIFT;
            N_SHIFT:  if (!any_hi) state_next = N_SQUARE;
            N_SQUARE: if (k_reg == 2'd2) state_next = N_SQRT;
            N_SQRT:   if (cnt_reg == CNTW'(RW - 1)) state_next = N_PREP;
            N_PREP:   state_next = N_DIV;
            N_DIV:    if (cnt_reg == CNTW'(QW - 1)) state_next = N_DONE;
            N_DONE:
            begin
                done       = 1'b1;
                state_next = start ? N_SHIFT : N_IDLE;
            end
            default:  state_next = N_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        logic [NW-1:0] num;
        logic [RW:0]   t;
        case (state_reg)
            N_IDLE, N_DONE:
            begin
                if (start)
                begin
                    a_reg[0]   <= mag(c_x);
                    a_reg[1]   <= mag(c_y);
                    a_reg[2]   <= mag(c_z);
                    neg_reg[0] <= c_x[CW-1];
                    neg_reg[1] <= c_y[CW-1];
                    neg_reg[2] <= c_z[CW-1];
                    n_reg      <= '0;
                    res_reg    <= '0;
                    bit_reg    <= BIT_INIT;
                    k_reg      <= '0;
                    cnt_reg    <= '0;
                end
            end
            N_SHIFT:
            begin
                if (any_hi)
                    for (int i = 0; i < 3; i++)
                        a_reg[i] <= a_reg[i] >> 1;
            end
            N_SQUARE:
            begin
                n_reg <= n_reg + SQW'(sq);
                k_reg <= k_reg + 1'b1;
            end
            N_SQRT:
            begin
                // one result bit per cycle
                if (n_reg >= trial)
                begin
                    n_reg   <= n_reg - trial;
                    res_reg <= (res_reg >> 1) + bit_reg;
                end
                else
                begin
                    res_reg <= res_reg >> 1;
                end
                bit_reg <= bit_reg >> 2;
                cnt_reg <= (cnt_reg == CNTW'(RW - 1)) ? '0 : cnt_reg + 1'b1;
            end
            N_PREP:
            begin
                // rounded numerator; its top bits are already below the root
                for (int i = 0; i < 3; i++)
                begin
                    num        = (NW'(a_reg[i][NB-1:0]) << FRAC_BITS) + NW'(root >> 1);
                    rem_reg[i] <= RW'(num[NW-1:QW]);
                    lo_reg[i]  <= num[QW-1:0];
                    q_reg[i]   <= '0;
                end
            end
            N_DIV:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    t = {rem_reg[i], lo_reg[i][QW-1]};
                    if (t >= {1'b0, root})
                    begin
                        rem_reg[i] <= RW'(t - {1'b0, root});
                        q_reg[i]   <= {q_reg[i][QW-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg[i] <= RW'(t);
                        q_reg[i]   <= {q_reg[i][QW-2:0], 1'b0};
                    end
                    lo_reg[i] <= lo_reg[i] << 1;
                end
                cnt_reg <= cnt_reg + 1'b1;
            end
            default: ;
        endcase
    end

    assign q_x = neg_reg[0] ? -$signed({1'b0, q_reg[0]}) : $signed({1'b0, q_reg[0]});
    assign q_y = neg_reg[1] ? -$signed({1'b0, q_reg[1]}) : $signed({1'b0, q_reg[1]});
    assign q_z = neg_reg[2] ? -$signed({1'b0, q_reg[2]}) : $signed({1'b0, q_reg[2]});

endmodule

// File: src/cvm_back.sv
module cvm_back
    import cvm_pkg::*;
#(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS = 16,
    localparam int WW = DATA_WIDTH + 1,
    localparam int CW = 2 * DATA_WIDTH + 2,
    localparam int EW = 2 + 3 * DATA_WIDTH + 3 * WW + 3 * CW
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          avail,
    input  logic [EW-1:0] entry,
    output logic          pop,
    cvm_row_if.source     row
);

    localparam int DW    = DATA_WIDTH;
    localparam int UW    = FRAC_BITS + 2;
    localparam int VW    = FRAC_BITS + 3;
    localparam int TW    = 2 * UW + 2;
    localparam int AW    = VW + DW + 2;
    localparam int OW    = AW + 2;
    localparam int XW    = (VW > DW) ? VW : DW;
    localparam int OFF_W = 3 * CW;
    localparam int OFF_P = OFF_W + 3 * WW;
    localparam int OFF_S = OFF_P + 3 * DW;
    localparam logic signed [TW-1:0] HALF_V = TW'(1) << (FRAC_BITS - 1);
    localparam logic signed [OW-1:0] HALF_O = OW'(1) << (FRAC_BITS - 1);
    localparam logic signed [OW-1:0] SMAX = OW'({(DW - 1){1'b1}});
    localparam logic signed [OW-1:0] SMIN = -SMAX - OW'(1);

    back_state_t state_reg, state_next;

    logic [1:0]           st_reg;
    logic signed [DW-1:0] p_reg [3];
    logic signed [CW-1:0] u_raw_reg [3];
    logic signed [VW-1:0] rows_reg [3][3];
    logic signed [DW-1:0] offs_reg [3];
    logic signed [AW-1:0] acc_reg;
    logic [1:0]           k_reg, j_reg;

    logic                 ov_reg;
    logic [1:0]           idx_reg, ost_reg;
    logic signed [DW-1:0] ex_reg, ey_reg, ez_reg, off_reg;
    logic                 last_reg;

    logic                 n_start, n_done, ld;
    logic signed [CW-1:0] n_x, n_y, n_z;
    logic signed [UW-1:0] q_x, q_y, q_z;

    logic [1:0]             e_st;
    logic signed [UW-1:0]   ca1, cb1, ca2, cb2;
    logic signed [2*UW-1:0] pr1, pr2;
    logic signed [TW-1:0]   vt, vr;
    logic [1:0]             jj;
    logic signed [VW+DW-1:0] prod;
    logic signed [OW-1:0]   neg, rnd, sat;
    logic signed [XW-1:0]   ext_x, ext_y, ext_z;

    cvm_norm #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_norm (
        .clk   (clk),
        .rst_n (rst_n),
        .start (n_start),
        .c_x   (n_x),
        .c_y   (n_y),
        .c_z   (n_z),
        .done  (n_done),
        .q_x   (q_x),
        .q_y   (q_y),
        .q_z   (q_z)
    );

    assign e_st = entry[OFF_S +: 2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= B_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        pop        = 1'b0;
        n_start    = 1'b0;
        ld         = 1'b0;
        n_x        = CW'($signed(entry[OFF_W + 2 * WW +: WW]));
        n_y        = CW'($signed(entry[OFF_W + WW +: WW]));
        n_z        = CW'($signed(entry[OFF_W +: WW]));
        case (state_reg)
            B_IDLE:
            begin
                if (avail)
                begin
                    pop = 1'b1;
                    if (e_st == ST_OK)
                    begin
                        n_start    = 1'b1;
                        state_next = B_NORM_W;
                    end
                    else
                    begin
                        state_next = B_EMIT;
                    end
                end
            end
            B_NORM_W:
            begin
                n_x = u_raw_reg[0];
                n_y = u_raw_reg[1];
                n_z = u_raw_reg[2];
                if (n_done)
                begin
                    n_start    = 1'b1;
                    state_next = B_NORM_U;
                end
            end
            B_NORM_U: if (n_done) state_next = B_CROSS;
            B_CROSS:  if (k_reg == 2'd2) state_next = B_OFFS;
            B_OFFS:   if (k_reg == 2'd2 && j_reg == 2'd3) state_next = B_EMIT;
            B_EMIT:
            begin
                ld = !ov_reg || row.ready;
                if (ld && k_reg == 2'd2)
                    state_next = B_IDLE;
            end
            default:  state_next = B_IDLE;
        endcase
    end

    // v = w x u, one component per cycle; w sits in row 2, u in row 0
    always_comb
    begin
        case (k_reg)
            2'd0:
            begin
                ca1 = UW'(rows_reg[2][1]); cb1 = UW'(rows_reg[0][2]);
                ca2 = UW'(rows_reg[2][2]); cb2 = UW'(rows_reg[0][1]);
            end
            2'd1:
            begin
                ca1 = UW'(rows_reg[2][2]); cb1 = UW'(rows_reg[0][0]);
                ca2 = UW'(rows_reg[2][0]); cb2 = UW'(rows_reg[0][2]);
            end
            default:
            begin
                ca1 = UW'(rows_reg[2][0]); cb1 = UW'(rows_reg[0][1]);
                ca2 = UW'(rows_reg[2][1]); cb2 = UW'(rows_reg[0][0]);
            end
        endcase
    end

    assign pr1 = ca1 * cb1;
    assign pr2 = ca2 * cb2;
    assign vt  = TW'(pr1) - TW'(pr2);
    assign vr  = (vt + HALF_V) >>> FRAC_BITS;

    // translation: one product per cycle, fourth step rounds and clamps
    assign jj   = (j_reg == 2'd3) ? 2'd0 : j_reg;
    assign prod = rows_reg[k_reg][jj] * p_reg[jj];
    assign neg  = -OW'(acc_reg);
    assign rnd  = (neg + HALF_O) >>> FRAC_BITS;
    assign sat  = (rnd > SMAX) ? SMAX : ((rnd < SMIN) ? SMIN : rnd);

    assign ext_x = XW'(rows_reg[k_reg][0]);
    assign ext_y = XW'(rows_reg[k_reg][1]);
    assign ext_z = XW'(rows_reg[k_reg][2]);

    always_ff @(posedge clk)
    begin
        case (state_reg)
            B_IDLE:
            begin
                if (avail)
                begin
                    st_reg       <= e_st;
                    p_reg[0]     <= $signed(entry[OFF_P + 2 * DW +: DW]);
                    p_reg[1]     <= $signed(entry[OFF_P + DW +: DW]);
                    p_reg[2]     <= $signed(entry[OFF_P +: DW]);
                    u_raw_reg[0] <= $signed(entry[2 * CW +: CW]);
                    u_raw_reg[1] <= $signed(entry[CW +: CW]);
                    u_raw_reg[2] <= $signed(entry[0 +: CW]);
                    for (int r = 0; r < 3; r++)
                    begin
                        offs_reg[r] <= '0;
                        for (int c = 0; c < 3; c++)
                            rows_reg[r][c] <= '0;
                    end
                    k_reg <= '0;
                end
            end
            B_NORM_W:
            begin
                if (n_done)
                begin
                    rows_reg[2][0] <= VW'(q_x);
                    rows_reg[2][1] <= VW'(q_y);
                    rows_reg[2][2] <= VW'(q_z);
                end
            end
            B_NORM_U:
            begin
                if (n_done)
                begin
                    rows_reg[0][0] <= VW'(q_x);
                    rows_reg[0][1] <= VW'(q_y);
                    rows_reg[0][2] <= VW'(q_z);
                    k_reg          <= '0;
                end
            end
            B_CROSS:
            begin
                rows_reg[1][k_reg] <= VW'(vr);
                k_reg   <= (k_reg == 2'd2) ? 2'd0 : k_reg + 1'b1;
                j_reg   <= '0;
                acc_reg <= '0;
            end
            B_OFFS:
            begin
                if (j_reg == 2'd3)
                begin
                    offs_reg[k_reg] <= sat[DW-1:0];
                    acc_reg         <= '0;
                    j_reg           <= '0;
                    k_reg           <= (k_reg == 2'd2) ? 2'd0 : k_reg + 1'b1;
                end
                else
                begin
                    acc_reg <= acc_reg + AW'(prod);
                    j_reg   <= j_reg + 1'b1;
                end
            end
            B_EMIT:
            begin
                if (ld)
                    k_reg <= (k_reg == 2'd2) ? 2'd0 : k_reg + 1'b1;
            end
            default: ;
        endcase
    end

    // output register: holds the last row while the next item is worked on
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ov_reg <= 1'b0;
        else if (ld)
            ov_reg <= 1'b1;
        else if (row.ready)
            ov_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (ld)
        begin
            idx_reg  <= k_reg;
            ex_reg   <= ext_x[DW-1:0];
            ey_reg   <= ext_y[DW-1:0];
            ez_reg   <= ext_z[DW-1:0];
            off_reg  <= offs_reg[k_reg];
            ost_reg  <= st_reg;
            last_reg <= k_reg == 2'd2;
        end
    end

    assign row.valid     = ov_reg;
    assign row.row_index = idx_reg;
    assign row.elem_x    = ex_reg;
    assign row.elem_y    = ey_reg;
    assign row.elem_z    = ez_reg;
    assign row.offset    = off_reg;
    assign row.status    = ost_reg;
    assign row.last_row  = last_reg;

endmodule

// File: src/camera_view_matrix_core.sv
// Channel   Modport        Transaction
// setup     cvm_setup_if   camera position, view direction, up vector (Q16.16)
// row       cvm_row_if     one view matrix row: basis vector, offset, status
//
// Front: accepts one setup transaction per cycle while the queue has room;
//   products are registered at accept, the entry is pushed once the queue has room.
// Back: pops the item, then runs the shared normalizer for w and for u
//   (shift steps, squaring of the components, square-root steps, a prep
//   step, divide steps and a done step each), then builds v, computes the
//   offsets and emits the 3 rows. Bad-w and zero-length items skip straight
//   to the 3 rows.
// Reset (rst_n, async low) clears the queue and all handshake state.
// A stalled row channel holds the back; the front keeps filling the queue.
module camera_view_matrix_core
    import cvm_pkg::*;
#(
    parameter int DATA_WIDTH  = 32,
    parameter int FRAC_BITS   = 16,
    parameter int QUEUE_DEPTH = 4
) (
    input  logic      clk,
    input  logic      rst_n,
    cvm_setup_if.sink setup,
    cvm_row_if.source row
);

    localparam int WW = DATA_WIDTH + 1;
    localparam int CW = 2 * DATA_WIDTH + 2;
    localparam int EW = 2 + 3 * DATA_WIDTH + 3 * WW + 3 * CW;

    logic          q_push, q_room, q_pop, q_avail;
    logic [EW-1:0] q_wdata, q_rdata;

    // classify (bad w, zero length) and form the raw u = up x w
    cvm_front #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .setup (setup),
        .room  (q_room),
        .push  (q_push),
        .entry (q_wdata)
    );

    // decouples the front from the iterative back
    cvm_fifo #(
        .WIDTH (EW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (q_wdata),
        .room  (q_room),
        .pop   (q_pop),
        .avail (q_avail),
        .rdata (q_rdata)
    );

    // normalize, build v, compute translations, emit the three rows
    cvm_back #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_back (
        .clk   (clk),
        .rst_n (rst_n),
        .avail (q_avail),
        .entry (q_rdata),
        .pop   (q_pop),
        .row   (row)
    );

endmodule

// File: test/camera_view_matrix_core_tb.sv
module camera_view_matrix_core_tb;
    import cvm_pkg::*;

    localparam int DW        = 32;
    localparam int FB        = 16;
    localparam int ONE       = 1 << FB;
    // cycles with no transaction on either side before we give up
    localparam int IDLE_LIMIT = 20000;
    localparam int N_RANDOM  = 420;
    localparam int QUIET_TAIL = 60;  // final items sent with no idling

    typedef struct {
        logic signed [DW-1:0] px, py, pz, pw;
        logic signed [DW-1:0] vx, vy, vz, vw;
        logic signed [DW-1:0] ux, uy, uz;
    } setup_t;

    typedef struct {
        logic [1:0]           idx;
        logic signed [DW-1:0] ex, ey, ez, offs;
        status_t              st;
        logic                 last;
    } mat_row_t;

    // Look-at matrix predictor plus the queue of rows still owed by the block.
    class view_matrix_sb;
        mat_row_t owed_rows[$];
        int       n_errors;

        function automatic logic [63:0] isqrt(logic [63:0] n);
            logic [63:0] res;
            logic [63:0] b;
            res = 0;
            b   = 64'd1 << 62;
            while (b > n) b = b >> 2;
            while (b != 0)
            begin
                if (n >= res + b)
                begin
                    n   = n - (res + b);
                    res = (res >> 1) + b;
                end
                else
                    res = res >> 1;
                b = b >> 2;
            end
            return res;
        endfunction

        // round from 2*FB to FB fraction bits, ties toward +inf (floor of x+half)
        function automatic longint rnd(longint x);
            return (x + (longint'(1) << (FB - 1))) >>> FB;
        endfunction

        // unit vector of c; returns 0 for the zero vector
        function automatic bit unit_vec(input logic signed [65:0] c[3], output longint q[3]);
            logic [65:0] a[3];
            logic [65:0] mx;
            logic [63:0] n, r, m;
            int s;
            mx = 0;
            for (int i = 0; i < 3; i++)
            begin
                a[i] = c[i] < 0 ? -c[i] : c[i];
                if (a[i] > mx) mx = a[i];
            end
            if (mx == 0) return 0;
            s = 0;
            while (((mx >> s) >> 31) != 0) s++;
            n = 0;
            for (int i = 0; i < 3; i++)
            begin
                a[i] = a[i] >> s;
                n = n + a[i][63:0] * a[i][63:0];
            end
            r = isqrt(n);
            for (int i = 0; i < 3; i++)
            begin
                m    = ((a[i][63:0] << FB) + (r >> 1)) / r;
                q[i] = c[i] < 0 ? -longint'(m) : longint'(m);
            end
            return 1;
        endfunction

        function void note_setup(setup_t s);
            logic signed [65:0] w_raw[3], t[3], u_raw[3];
            longint  p[3], wn[3], un[3], vn[3], basis[3][3], off[3], d;
            status_t st;
            mat_row_t r;
            p = '{longint'(s.px), longint'(s.py), longint'(s.pz)};
            w_raw = '{-66'(s.vx), -66'(s.vy), -66'(s.vz)};
            t     = '{66'(s.ux), 66'(s.uy), 66'(s.uz)};
            basis = '{'{0, 0, 0}, '{0, 0, 0}, '{0, 0, 0}};
            off   = '{0, 0, 0};
            st    = ST_OK;
            if (s.pw != ONE || s.vw != 0)
                st = ST_BAD_W;
            else
            begin
                u_raw[0] = t[1] * w_raw[2] - t[2] * w_raw[1];
                u_raw[1] = t[2] * w_raw[0] - t[0] * w_raw[2];
                u_raw[2] = t[0] * w_raw[1] - t[1] * w_raw[0];
                if (!unit_vec(w_raw, wn) || !unit_vec(u_raw, un))
                    st = ST_ZERO_LEN;
                else
                begin
                    vn[0] = rnd(wn[1] * un[2] - wn[2] * un[1]);
                    vn[1] = rnd(wn[2] * un[0] - wn[0] * un[2]);
                    vn[2] = rnd(wn[0] * un[1] - wn[1] * un[0]);
                    basis = '{un, vn, wn};
                    for (int k = 0; k < 3; k++)
                    begin
                        d = basis[k][0] * p[0] + basis[k][1] * p[1] + basis[k][2] * p[2];
                        off[k] = rnd(-d);
                        if (off[k] > 64'sh7fff_ffff) off[k] = 64'sh7fff_ffff;
                        if (off[k] < -64'sh8000_0000) off[k] = -64'sh8000_0000;
                    end
                end
            end
            for (int k = 0; k < 3; k++)
            begin
                r.idx  = k[1:0];
                r.ex   = basis[k][0][DW-1:0];
                r.ey   = basis[k][1][DW-1:0];
                r.ez   = basis[k][2][DW-1:0];
                r.offs = off[k][DW-1:0];
                r.st   = st;
                r.last = (k == 2);
                owed_rows.push_back(r);
            end
        endfunction

        function void check_row(mat_row_t got);
            mat_row_t exp_r;
            if (owed_rows.size() == 0)
            begin
                $error("row transaction with nothing expected (row_index %0d)", got.idx);
                n_errors++;
                return;
            end
            exp_r = owed_rows.pop_front();
            if (got.idx !== exp_r.idx)
            begin
                $error("row_index: expected %0d, got %0d", exp_r.idx, got.idx);
                n_errors++;
            end
            if (got.ex !== exp_r.ex)
            begin
                $error("elem_x: expected %0d, got %0d", exp_r.ex, got.ex);
                n_errors++;
            end
            if (got.ey !== exp_r.ey)
            begin
                $error("elem_y: expected %0d, got %0d", exp_r.ey, got.ey);
                n_errors++;
            end
            if (got.ez !== exp_r.ez)
            begin
                $error("elem_z: expected %0d, got %0d", exp_r.ez, got.ez);
                n_errors++;
            end
            if (got.offs !== exp_r.offs)
            begin
                $error("offset: expected %0d, got %0d", exp_r.offs, got.offs);
                n_errors++;
            end
            if (got.st !== exp_r.st)
            begin
                $error("status: expected %0d, got %0d", exp_r.st, got.st);
                n_errors++;
            end
            if (got.last !== exp_r.last)
            begin
                $error("last_row: expected %0d, got %0d", exp_r.last, got.last);
                n_errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;

    cvm_setup_if #(.DATA_WIDTH(DW)) setup_ch ();
    cvm_row_if   #(.DATA_WIDTH(DW)) row_ch ();

    camera_view_matrix_core #(.DATA_WIDTH(DW), .FRAC_BITS(FB)) DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .setup (setup_ch),
        .row   (row_ch)
    );

    view_matrix_sb sb;
    bit quiet_tail;     // set for the last part of the run: no idling anywhere
    int idle_cycles;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Watchdog: any transaction on either channel resets the count.
    always @(posedge clk)
    begin
        if ((setup_ch.valid && setup_ch.ready) || (row_ch.valid && row_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Row sink: random stall bursts, none in the tail.
    initial
    begin
        mat_row_t got;
        int stall;
        row_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (stall > 0)
            begin
                stall--;
                row_ch.ready = 1'b0;
            end
            else if (!quiet_tail && $urandom_range(0, 9) == 0)
            begin
                stall = $urandom_range(1, 18) - 1;
                row_ch.ready = 1'b0;
            end
            else
                row_ch.ready = 1'b1;
            @(posedge clk);
            if (row_ch.valid && row_ch.ready)
            begin
                got.idx  = row_ch.row_index;
                got.ex   = row_ch.elem_x;
                got.ey   = row_ch.elem_y;
                got.ez   = row_ch.elem_z;
                got.offs = row_ch.offset;
                got.st   = status_t'(row_ch.status);
                got.last = row_ch.last_row;
                sb.check_row(got);
            end
        end
    end

    // Drive one setup transaction; fields change at the falling edge.
    task automatic send_setup(setup_t s);
        int gap;
        if (!quiet_tail && $urandom_range(0, 7) == 0)
        begin
            gap = $urandom_range(1, 18);
            setup_ch.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        setup_ch.valid  = 1'b1;
        setup_ch.pos_x  = s.px;
        setup_ch.pos_y  = s.py;
        setup_ch.pos_z  = s.pz;
        setup_ch.pos_w  = s.pw;
        setup_ch.view_x = s.vx;
        setup_ch.view_y = s.vy;
        setup_ch.view_z = s.vz;
        setup_ch.view_w = s.vw;
        setup_ch.up_x   = s.ux;
        setup_ch.up_y   = s.uy;
        setup_ch.up_z   = s.uz;
        do @(posedge clk); while (!setup_ch.ready);
        sb.note_setup(s);
        @(negedge clk);
        setup_ch.valid = 1'b0;
    endtask

    task automatic wait_drained();
        while (sb.owed_rows.size() != 0) @(negedge clk);
    endtask

    function automatic logic signed [DW-1:0] pick_val(int full_pct);
        if ($urandom_range(0, 99) < full_pct)
            return $urandom;
        // mostly modest values, +-8.0 in Q16.16
        return $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
    endfunction

    function automatic setup_t mk(int px, int py, int pz, int pw, int vx, int vy, int vz,
                                  int vw, int ux, int uy, int uz);
        setup_t s;
        s = '{px, py, pz, pw, vx, vy, vz, vw, ux, uy, uz};
        return s;
    endfunction

    initial
    begin
        setup_t s;
        setup_t directed[$];
        int kind;
        int full_pct;
        sb = new();
        quiet_tail  = 1'b0;
        idle_cycles = 0;
        setup_ch.valid = 1'b0;
        {setup_ch.pos_x, setup_ch.pos_y, setup_ch.pos_z, setup_ch.pos_w} = '0;
        {setup_ch.view_x, setup_ch.view_y, setup_ch.view_z, setup_ch.view_w} = '0;
        {setup_ch.up_x, setup_ch.up_y, setup_ch.up_z} = '0;
        rst_n = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: identity look-at, field extremes, every status case.
        directed.push_back(mk(0, 0, 0, ONE, 0, 0, -ONE, 0, 0, ONE, 0));
        directed.push_back(mk(3*ONE, -2*ONE, 5*ONE, ONE, ONE, 2*ONE, -ONE, 0, 0, ONE, 0));
        directed.push_back(mk(32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff, ONE,
                              ONE, ONE, ONE, 0, 0, ONE, 0));
        directed.push_back(mk(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, ONE,
                              ONE, ONE, ONE, 0, 0, ONE, 0));
        directed.push_back(mk(ONE, ONE, ONE, ONE, 32'sh8000_0000, 32'sh7fff_ffff, 1, 0,
                              32'sh7fff_ffff, 32'sh8000_0000, 32'sh8000_0000));
        directed.push_back(mk(0, 0, 0, ONE, 1, 0, 0, 0, 0, 0, 1));
        directed.push_back(mk(0, 0, 0, ONE, 32'sh7fff_ffff, 0, 0, 0, 0, 32'sh7fff_ffff, 0));
        // bad homogeneous w: position, view, both, and over a zero view
        directed.push_back(mk(0, 0, 0, ONE + 1, 0, 0, -ONE, 0, 0, ONE, 0));
        directed.push_back(mk(0, 0, 0, ONE, 0, 0, -ONE, ONE, 0, ONE, 0));
        directed.push_back(mk(0, 0, 0, 32'sh8000_0000, 0, 0, 0, 32'sh7fff_ffff, 0, 0, 0));
        directed.push_back(mk(0, 0, 0, 0, 0, 0, -ONE, -1, 0, ONE, 0));
        directed.push_back(mk(0, 0, 0, 32'sh7fff_ffff, 0, 0, -ONE, 32'sh8000_0000,
                              0, ONE, 0));
        // zero-length: zero view, zero up, up parallel to view
        directed.push_back(mk(ONE, ONE, ONE, ONE, 0, 0, 0, 0, 0, ONE, 0));
        directed.push_back(mk(ONE, ONE, ONE, ONE, 0, 0, -ONE, 0, 0, 0, 0));
        directed.push_back(mk(ONE, ONE, ONE, ONE, ONE, 2*ONE, 3*ONE, 0,
                              -2*ONE, -4*ONE, -6*ONE));
        directed.push_back(mk(-ONE, 7*ONE, 0, ONE, 0, -5*ONE, 0, 0, 0, ONE, 0));
        foreach (directed[i]) send_setup(directed[i]);

        for (int n = 0; n < N_RANDOM; n++)
        begin
            if (n == N_RANDOM - QUIET_TAIL) quiet_tail = 1'b1;
            // Let the block drain completely before continuing.
            if (n == N_RANDOM / 3 || n == 2 * N_RANDOM / 3) wait_drained();
            full_pct = $urandom_range(0, 1) ? 100 : 15;
            kind = $urandom_range(0, 99);
            s.px = pick_val(full_pct);
            s.py = pick_val(full_pct);
            s.pz = pick_val(full_pct);
            s.vx = pick_val(full_pct);
            s.vy = pick_val(full_pct);
            s.vz = pick_val(full_pct);
            s.ux = pick_val(full_pct);
            s.uy = pick_val(full_pct);
            s.uz = pick_val(full_pct);
            s.pw = ONE;
            s.vw = 0;
            if (kind < 8)
                s.pw = $urandom;                 // noisy homogeneous w
            else if (kind < 16)
                s.vw = $urandom;
            else if (kind < 20)
                {s.vx, s.vy, s.vz} = '0;         // zero view
            else if (kind < 24)
            begin
                // up parallel to view (small view keeps the scaled copy in range)
                s.vx = $urandom_range(0, 2048) - 1024;
                s.vy = $urandom_range(0, 2048) - 1024;
                s.vz = $urandom_range(0, 2048) - 1024;
                full_pct = $urandom_range(0, 200) - 100;
                s.ux = s.vx * full_pct;
                s.uy = s.vy * full_pct;
                s.uz = s.vz * full_pct;
            end
            else if (kind < 27)
                {s.ux, s.uy, s.uz} = '0;
            send_setup(s);
        end

        wait_drained();
        repeat (300) @(negedge clk);
        if (sb.n_errors == 0 && sb.owed_rows.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
